[rtl/ascii_to_unsigned_parser_core_defines.svh]
// Assertion macros for the parser core checkers.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef ASCII_TO_UNSIGNED_PARSER_CORE_DEFINES_SVH
`define ASCII_TO_UNSIGNED_PARSER_CORE_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASCP_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASCP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ascp_pkg.sv]
package ascp_pkg;

   localparam int VALUE_BITS     = 64;
   localparam int MAX_CHARS      = 65535;
   localparam int POS_BITS       = $clog2(MAX_CHARS + 1);
   localparam int CHAR_BITS      = 8;
   localparam int BASE_BITS      = 6;
   localparam int DIGIT_BITS     = BASE_BITS + 1;
   localparam int VALUE_OUT_BITS = 64;
   localparam int OFFSET_BITS    = 16;

   localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;
   localparam logic [BASE_BITS-1:0] BASE_AUTO  = 6'd0;
   localparam logic [BASE_BITS-1:0] BASE_MIN   = 6'd2;
   localparam logic [BASE_BITS-1:0] BASE_MAX   = 6'd36;
   localparam logic [BASE_BITS-1:0] BASE_OCT   = 6'd8;
   localparam logic [BASE_BITS-1:0] BASE_DEC   = 6'd10;
   localparam logic [BASE_BITS-1:0] BASE_HEX   = 6'd16;

   localparam logic [DIGIT_BITS-1:0] NO_DIGIT     = 7'd99;
   localparam logic [DIGIT_BITS-1:0] LETTER_FIRST = 7'd10;

   localparam logic [CHAR_BITS-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_BITS-1:0] CH_LF    = 8'h0A;
   localparam logic [CHAR_BITS-1:0] CH_VT    = 8'h0B;
   localparam logic [CHAR_BITS-1:0] CH_FF    = 8'h0C;
   localparam logic [CHAR_BITS-1:0] CH_CR    = 8'h0D;
   localparam logic [CHAR_BITS-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE  = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_UC_A  = 8'h41;
   localparam logic [CHAR_BITS-1:0] CH_UC_X  = 8'h58;
   localparam logic [CHAR_BITS-1:0] CH_UC_Z  = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CH_LC_A  = 8'h61;
   localparam logic [CHAR_BITS-1:0] CH_LC_X  = 8'h78;
   localparam logic [CHAR_BITS-1:0] CH_LC_Z  = 8'h7A;

   typedef enum logic [2:0] {
      PH_SPACE,
      PH_PREFIX,
      PH_ZERO,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] text_char;
      logic                 is_last;
   } char_beat_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0]  value;
      logic                   minus;
      logic [OFFSET_BITS-1:0] offset;
      logic                   had_digits;
   } rslt_type;

   function automatic logic [DIGIT_BITS-1:0] char_digit(input logic [CHAR_BITS-1:0] c);
      logic [CHAR_BITS-1:0] d;
      d = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = c - CH_ZERO;
         return DIGIT_BITS'(d);
      end
      if (c >= CH_LC_A && c <= CH_LC_Z) begin
         d = c - CH_LC_A;
         return DIGIT_BITS'(d) + LETTER_FIRST;
      end
      if (c >= CH_UC_A && c <= CH_UC_Z) begin
         d = c - CH_UC_A;
         return DIGIT_BITS'(d) + LETTER_FIRST;
      end
      return NO_DIGIT;
   endfunction

   function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
             (c == CH_CR) || (c == CH_FF) || (c == CH_VT);
   endfunction

endpackage

[rtl/ascp_if.sv]
interface ascp_req_if import ascp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] text_char;
   logic                 is_last;

   modport source (output valid, output text_char, output is_last, input ready);
   modport sink   (input valid, input text_char, input is_last, output ready);
endinterface

interface ascp_rsp_if import ascp_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [VALUE_OUT_BITS-1:0] parsed_value;
   logic [OFFSET_BITS-1:0]    end_offset;
   logic                      had_digits;

   modport source (output valid, output parsed_value, output end_offset,
                   output had_digits, input ready);
   modport sink   (input valid, input parsed_value, input end_offset,
                   input had_digits, output ready);
endinterface

[rtl/ascp_in_stage.sv]
module ascp_in_stage import ascp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   ascp_req_if.sink      req,
   output logic          beat_valid,
   output char_beat_type beat,
   input  logic          beat_ready
);

   logic          valid_ff;
   logic          valid_in;
   char_beat_type beat_ff;
   logic          take;

   assign req.ready = !valid_ff || beat_ready;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff && !beat_ready;
      if (take) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         beat_ff.text_char <= req.text_char;
         beat_ff.is_last   <= req.is_last;
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

[rtl/ascp_parse_unit.sv]
module ascp_parse_unit import ascp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [BASE_BITS-1:0] number_base,
   input  logic                 beat_valid,
   input  char_beat_type        beat,
   output logic                 beat_ready,
   output logic                 rslt_valid,
   input  logic                 rslt_ready,
   output rslt_type             rslt
);

   phase_type                       phase_ff, phase_in;
   logic [BASE_BITS-1:0]            base_ff, base_in;
   logic                            minus_ff, minus_in;
   logic [VALUE_BITS-1:0]           acc_ff, acc_in;
   logic [POS_BITS-1:0]             pos_ff, pos_in;
   logic [POS_BITS-1:0]             dend_ff, dend_in;
   logic                            anyd_ff, anyd_in;
   logic                            rslt_valid_ff, rslt_valid_in;
   rslt_type                        rslt_ff, rslt_in;

   logic                            take;
   logic                            base_ok;
   logic                            do_prefix;
   logic                            do_zero;
   logic                            run_digit;
   logic [BASE_BITS-1:0]            dig_base;
   logic [DIGIT_BITS-1:0]           digit;
   logic [VALUE_BITS+BASE_BITS-1:0] prod;
   logic [CHAR_BITS-1:0]            c;

   assign beat_ready = !beat.is_last || !rslt_valid_ff || rslt_ready;
   assign take       = beat_valid && beat_ready;
   assign c          = beat.text_char;
   assign base_ok    = (number_base == BASE_AUTO) ||
                       ((number_base >= BASE_MIN) && (number_base <= BASE_MAX));
   assign digit      = char_digit(c);

   always_comb begin
      phase_in      = phase_ff;
      base_in       = base_ff;
      minus_in      = minus_ff;
      acc_in        = acc_ff;
      pos_in        = pos_ff;
      dend_in       = dend_ff;
      anyd_in       = anyd_ff;
      rslt_in       = rslt_ff;
      rslt_valid_in = rslt_valid_ff && !rslt_ready;
      do_prefix     = 1'b0;
      do_zero       = 1'b0;
      run_digit     = 1'b0;
      dig_base      = base_ff;
      prod          = '0;

      if (take && (pos_ff < POS_BITS'(MAX_CHARS))) begin
         pos_in = pos_ff + 1'b1;
         case (phase_ff)
            PH_SPACE: begin
               if (!is_space(c)) begin
                  phase_in = PH_PREFIX;
                  if (c == CH_PLUS || c == CH_MINUS) begin
                     minus_in = (c == CH_MINUS);
                  end else begin
                     do_prefix = 1'b1;
                  end
               end
            end
            PH_PREFIX: do_prefix = 1'b1;
            PH_ZERO:   do_zero   = 1'b1;
            PH_DIGITS: run_digit = 1'b1;
            default:   ;
         endcase

         // decide the base on the first character after white space and sign
         if (do_prefix) begin
            if (!base_ok) begin
               phase_in = PH_DONE;
            end else if ((number_base == BASE_AUTO || number_base == BASE_HEX) &&
                         c == CH_ZERO) begin
               acc_in   = '0;
               anyd_in  = 1'b1;
               dend_in  = pos_ff + 1'b1;
               phase_in = PH_ZERO;
            end else begin
               dig_base  = (number_base == BASE_AUTO) ? BASE_DEC : number_base;
               base_in   = dig_base;
               phase_in  = PH_DIGITS;
               run_digit = 1'b1;
            end
         end

         // after a leading zero: swallow an x prefix or fall into octal/hex digits
         if (do_zero) begin
            if (c == CH_LC_X || c == CH_UC_X) begin
               base_in  = BASE_HEX;
               phase_in = PH_DIGITS;
            end else begin
               dig_base  = (number_base == BASE_AUTO) ? BASE_OCT : BASE_HEX;
               base_in   = dig_base;
               phase_in  = PH_DIGITS;
               run_digit = 1'b1;
            end
         end

         if (run_digit) begin
            if (digit < DIGIT_BITS'(dig_base)) begin
               prod    = {{BASE_BITS{1'b0}}, acc_ff} * {{VALUE_BITS{1'b0}}, dig_base};
               acc_in  = prod[VALUE_BITS-1:0] + VALUE_BITS'(digit);
               anyd_in = 1'b1;
               dend_in = pos_ff + 1'b1;
            end else begin
               phase_in = PH_DONE;
            end
         end
      end

      // emit on the last beat, then clear for the next string
      if (take && beat.is_last) begin
         rslt_valid_in      = 1'b1;
         rslt_in.value      = anyd_in ? acc_in : '0;
         rslt_in.minus      = minus_in;
         rslt_in.offset     = anyd_in ? OFFSET_BITS'(dend_in) : '0;
         rslt_in.had_digits = anyd_in;
         phase_in           = PH_SPACE;
         base_in            = '0;
         minus_in           = 1'b0;
         acc_in             = '0;
         pos_in             = '0;
         dend_in            = '0;
         anyd_in            = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SPACE;
         base_ff       <= '0;
         minus_ff      <= 1'b0;
         acc_ff        <= '0;
         pos_ff        <= '0;
         dend_ff       <= '0;
         anyd_ff       <= 1'b0;
         rslt_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         base_ff       <= base_in;
         minus_ff      <= minus_in;
         acc_ff        <= acc_in;
         pos_ff        <= pos_in;
         dend_ff       <= dend_in;
         anyd_ff       <= anyd_in;
         rslt_valid_ff <= rslt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rslt_ff <= rslt_in;
   end

   assign rslt_valid = rslt_valid_ff;
   assign rslt       = rslt_ff;

endmodule

[rtl/ascp_out_stage.sv]
module ascp_out_stage import ascp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      rslt_valid,
   input  rslt_type  rslt,
   output logic      rslt_ready,
   ascp_rsp_if.source rsp
);

   logic                      valid_ff, valid_in;
   logic [VALUE_OUT_BITS-1:0] value_ff;
   logic [OFFSET_BITS-1:0]    offset_ff;
   logic                      had_ff;
   logic [VALUE_BITS-1:0]     sign_applied;
   logic                      take;

   assign rslt_ready   = !valid_ff || rsp.ready;
   assign take         = rslt_valid && rslt_ready;
   assign sign_applied = rslt.minus ? (VALUE_BITS'(0) - rslt.value) : rslt.value;

   always_comb begin
      valid_in = valid_ff && !rsp.ready;
      if (take) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         value_ff  <= VALUE_OUT_BITS'(sign_applied);
         offset_ff <= rslt.offset;
         had_ff    <= rslt.had_digits;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.parsed_value = value_ff;
   assign rsp.end_offset   = offset_ff;
   assign rsp.had_digits   = had_ff;

endmodule

[rtl/ascii_to_unsigned_parser_core.sv]
// Path: a last character taken by the input register moves through the parse stage
// and the output register before its result shows on rsp. Throughput: one character
// per clock by the accumulator multiply-add loop; a last one waits for a held result.
// Reset: synchronous, active high; empties the pipeline, clears the per-string
// state and returns number_base to 10. No clearing pass, ready again at once.
module ascii_to_unsigned_parser_core import ascp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   ascp_req_if.sink             req_bus,
   ascp_rsp_if.source           rsp_bus,
   input  logic                 csr_wr_en,
   input  logic [BASE_BITS-1:0] csr_wr_data
);

   // Configured radix: sampled by the parse stage when a string decides its base.
   logic [BASE_BITS-1:0] number_base_ff;
   logic [BASE_BITS-1:0] number_base_in;

   // Input register to parse stage
   logic          beat_valid;
   char_beat_type beat;
   logic          beat_ready;

   // Parse stage to output register: raw value plus sign, negated on the way out
   logic     rslt_valid;
   rslt_type rslt;
   logic     rslt_ready;

   always_comb begin
      number_base_in = number_base_ff;
      if (csr_wr_en) begin
         number_base_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         number_base_ff <= BASE_RESET;
      end else begin
         number_base_ff <= number_base_in;
      end
   end

   // Register each accepted beat until the parse stage takes it; a non-last beat always moves on,
   // so the skid only stalls when a finished result is still waiting.
   ascp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .beat_valid (beat_valid),
      .beat       (beat),
      .beat_ready (beat_ready)
   );

   // Advance the white space / sign / prefix / digit state machine and the
   // accumulator by one character; register a result on the last beat.
   ascp_parse_unit u_parse_unit (
      .clock       (clock),
      .reset       (reset),
      .number_base (number_base_ff),
      .beat_valid  (beat_valid),
      .beat        (beat),
      .beat_ready  (beat_ready),
      .rslt_valid  (rslt_valid),
      .rslt_ready  (rslt_ready),
      .rslt        (rslt)
   );

   // Apply the minus sign and drive the result beat.
   ascp_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .rslt_valid (rslt_valid),
      .rslt       (rslt),
      .rslt_ready (rslt_ready),
      .rsp        (rsp_bus)
   );

endmodule

[rtl/ascp_checker.sv]
`include "ascii_to_unsigned_parser_core_defines.svh"

module ascp_checker import ascp_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [VALUE_OUT_BITS-1:0] rsp_parsed_value,
   input logic [OFFSET_BITS-1:0]    rsp_end_offset,
   input logic                      rsp_had_digits
);

   `ASCP_ASSERT_NEXT(a_rsp_valid_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp beat dropped while stalled")
   `ASCP_ASSERT_NEXT(a_rsp_payload_hold, rsp_valid && !rsp_ready, $stable(rsp_parsed_value) && $stable(rsp_end_offset) && $stable(rsp_had_digits), "rsp payload changed while stalled")
   `ASCP_ASSERT_IMPL(a_no_digit_zero, rsp_valid && !rsp_had_digits, rsp_parsed_value == '0 && rsp_end_offset == '0, "result without digits is not zero")
   `ASCP_ASSERT_IMPL(a_digit_offset, rsp_valid && rsp_had_digits, rsp_end_offset != '0, "result with digits has zero end offset")

endmodule

bind ascii_to_unsigned_parser_core ascp_checker u_ascp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_parsed_value (rsp_bus.parsed_value),
   .rsp_end_offset   (rsp_bus.end_offset),
   .rsp_had_digits   (rsp_bus.had_digits)
);
